/* design/srbs_pkg.sv */
// shared types and constants for the sorted range bounds search block
// no dependencies; imported by srbs_bound and sorted_range_bounds_search
package srbs_pkg;

  localparam int KEY_W = 32;  // table entry and key width
  localparam int IDX_W = 10;  // write index field width
  localparam int CNT_W = 11;  // used_count register width
  localparam int POS_W = 11;  // signed result position width

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // position reported when the key is absent (-1)
  localparam logic [POS_W-1:0] NOT_FOUND = '1;

  // status of one bound search engine
  typedef struct packed {
    logic done;   // no probe outstanding, pos is final
    logic match;  // entry at the last hit probe equals the key
  } bound_status_t;

endpackage

/* design/srbs_bound.sv */
// one binary search engine (lower or upper bound) over the table memory
// depends on srbs_pkg; the memory read port lives in the top level
module srbs_bound #(
  parameter int CW     = 11,
  parameter int AW     = 10,
  parameter bit STRICT = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [CW-1:0]                      n,
  input  logic signed [srbs_pkg::KEY_W-1:0]  key,
  input  logic signed [srbs_pkg::KEY_W-1:0]  rd_data,
  output logic [AW-1:0]                      rd_addr,
  output logic [CW-1:0]                      pos,
  output srbs_pkg::bound_status_t            status
);
  import srbs_pkg::*;

  logic [CW-1:0]            lo, lo_next;
  logic [CW-1:0]            hi, hi_next;   // exclusive upper limit
  logic [CW-1:0]            mid;           // address of the probe in flight
  logic [CW-1:0]            mid_next;
  logic [CW:0]              mid_sum;
  logic                     busy, busy_next;
  logic                     match, match_next;
  logic signed [KEY_W-1:0]  key_reg;
  logic                     hit;

  assign hit = STRICT ? (rd_data > key_reg) : (rd_data >= key_reg);

  always_comb begin
    lo_next    = lo;
    hi_next    = hi;
    match_next = match;
    priority if (start) begin
      lo_next    = '0;
      hi_next    = n;
      match_next = 1'b0;
    end else if (busy) begin
      if (hit) begin
        hi_next    = mid;
        match_next = (rd_data == key_reg);
      end else begin
        lo_next = mid + CW'(1);
      end
    end else begin
      // no search in progress, window holds
      lo_next = lo;
    end
    busy_next = (start || busy) ? (lo_next < hi_next) : 1'b0;
    mid_sum   = {1'b0, lo_next} + {1'b0, hi_next} - (CW+1)'(1);
    mid_next  = mid_sum[CW:1];
  end

  // next probe address goes straight to the registered memory read
  assign rd_addr = AW'(mid_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      lo    <= '0;
      hi    <= '0;
      busy  <= 1'b0;
      match <= 1'b0;
    end else begin
      lo    <= lo_next;
      hi    <= hi_next;
      busy  <= busy_next;
      match <= match_next;
    end
    mid <= mid_next;
    if (start) begin
      key_reg <= key;
    end
  end

  assign pos          = lo;
  assign status.done  = !busy;
  assign status.match = match;

  a_busy_open: assert property (@(posedge clk) disable iff (rst) busy |-> lo < hi)
    else $error("search window empty while a probe is outstanding");
  a_done_closed: assert property (@(posedge clk) disable iff (rst) !busy |-> lo == hi)
    else $error("search window not closed at completion");
  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    busy |-> (mid >= lo && mid < hi))
    else $error("probe address outside the search window");

endmodule

/* design/sorted_range_bounds_search.sv */
// top level: table memory, two bound search engines, item and result control
// depends on srbs_pkg and srbs_bound
// write items are taken back to back; a query stalls the item channel until its
// result is loaded, after up to P = floor(log2(n))+1 probes (0 when n is 0);
// both bounds probe in parallel, one probe per cycle on separate read ports
// result is registered: loaded once both searches are done and the result slot is free
// rst (synchronous) clears used_count and control; table contents undefined
module sorted_range_bounds_search #(
  parameter int DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srbs_pkg::CNT_W-1:0]         used_count,
  // item channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               op,
  input  logic [srbs_pkg::IDX_W-1:0]         entry_index,
  input  logic signed [srbs_pkg::KEY_W-1:0]  entry_value,
  input  logic signed [srbs_pkg::KEY_W-1:0]  search_key,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               found,
  output logic signed [srbs_pkg::POS_W-1:0]  first_pos,
  output logic signed [srbs_pkg::POS_W-1:0]  last_pos
);
  import srbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // table address width
  localparam int CW = $clog2(DEPTH + 1);                // count / bound width
  localparam int XW = (CW > POS_W) ? CW : POS_W;        // position math width

  typedef enum logic {IDLE, RUN} state_t;

  state_t                   state;
  logic [CNT_W-1:0]         used_reg;
  logic [CW-1:0]            n_act;
  logic [CW-1:0]            n_reg;

  // table memory: one write port, two registered read ports
  logic signed [KEY_W-1:0]  table_mem [DEPTH];
  logic signed [KEY_W-1:0]  rd_data_lo, rd_data_up;
  logic [AW-1:0]            rd_addr_lo, rd_addr_up;

  logic                     item_xfer;
  logic                     wr_en;
  logic                     query_start;

  logic [CW-1:0]            pos_lo, pos_up;
  bound_status_t            lo_st, up_st;
  logic                     hit_found;
  logic [XW-1:0]            first_x, last_x;
  logic                     slot_free;

  // register is always writable; writes must come only while the block is idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      used_reg <= used_count;
    end
  end

  // counts above the table depth clamp to the depth
  assign n_act = (32'(used_reg) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(used_reg);

  // items are taken only between queries; a query owns both read ports
  assign item_stall  = (state == RUN);
  assign item_xfer   = item_valid && !item_stall;
  assign query_start = item_xfer && (op == OP_QUERY);
  // writes beyond the table are dropped
  assign wr_en       = item_xfer && (op == OP_WRITE) && (32'(entry_index) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[AW'(entry_index)] <= entry_value;
    end
    rd_data_lo <= table_mem[rd_addr_lo];
    rd_data_up <= table_mem[rd_addr_up];
  end

  // lower bound: first entry >= key
  srbs_bound #(.CW(CW), .AW(AW), .STRICT(1'b0)) u_lower (
    .clk     (clk),
    .rst     (rst),
    .start   (query_start),
    .n       (n_act),
    .key     (search_key),
    .rd_data (rd_data_lo),
    .rd_addr (rd_addr_lo),
    .pos     (pos_lo),
    .status  (lo_st)
  );

  // upper bound: first entry > key
  srbs_bound #(.CW(CW), .AW(AW), .STRICT(1'b1)) u_upper (
    .clk     (clk),
    .rst     (rst),
    .start   (query_start),
    .n       (n_act),
    .key     (search_key),
    .rd_data (rd_data_up),
    .rd_addr (rd_addr_up),
    .pos     (pos_up),
    .status  (up_st)
  );

  // the last hit probe of the lower search is the entry at the lower bound
  assign hit_found = (pos_lo != n_reg) && lo_st.match;
  assign first_x   = XW'(pos_lo);
  // upper bound of 0 wraps to all ones, i.e. -1
  assign last_x    = XW'(pos_up) - XW'(1);
  assign slot_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (query_start) begin
            state <= RUN;
            n_reg <= n_act;
          end
          if (result_valid && !result_stall) begin
            result_valid <= 1'b0;
          end
        end
        RUN: begin
          priority if (lo_st.done && up_st.done && slot_free) begin
            // load the result register, previous result already transferred or leaving now
            result_valid <= 1'b1;
            found        <= hit_found;
            first_pos    <= hit_found ? first_x[POS_W-1:0] : NOT_FOUND;
            last_pos     <= hit_found ? last_x[POS_W-1:0]  : NOT_FOUND;
            state        <= IDLE;
          end else if (result_valid && !result_stall) begin
            result_valid <= 1'b0;
          end else begin
            result_valid <= result_valid;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_idle_engines_done: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (lo_st.done && up_st.done))
    else $error("search engine still busy while idle");
  a_query_runs: assert property (@(posedge clk) disable iff (rst)
    query_start |=> (state == RUN))
    else $error("query transfer did not start a search");
  a_miss_positions: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (first_pos == NOT_FOUND && last_pos == NOT_FOUND))
    else $error("miss result with a position other than -1");

endmodule

/* test/tb_sorted_range_bounds_search.sv */
`timescale 1ns / 100ps
// testbench for sorted_range_bounds_search: sorted and unsorted tables, queries checked
// against an in-bench lower/upper bound predictor; depends on srbs_pkg and the block
module tb_sorted_range_bounds_search;
  import srbs_pkg::*;

  localparam int DEPTH = 1024;
  localparam int ITEMS_TARGET = 1950;
  localparam int CALM_FROM = 1700;      // no idling on either side past this many items
  localparam int SETTLE_CYCLES = 16;    // longest query is 11 probes plus overhead
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
  } bounds_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         used_count;
  logic                     item_valid;
  logic                     item_stall;
  logic                     op;
  logic [IDX_W-1:0]         entry_index;
  logic signed [KEY_W-1:0]  entry_value;
  logic signed [KEY_W-1:0]  search_key;
  logic                     result_valid;
  logic                     result_stall;
  logic                     found;
  logic signed [POS_W-1:0]  first_pos;
  logic signed [POS_W-1:0]  last_pos;

  // bench copy of the table and the count register, updated at each transfer
  logic signed [KEY_W-1:0]  entry_copy [0:DEPTH-1];
  logic [CNT_W-1:0]         count_copy;
  bounds_t                  bounds_due [$];   // predicted results, oldest first

  int items_sent;
  int mismatch_count;
  bit calm;       // set for the last part of the run
  bit gaps_on;    // sender idles in bursts during this phase

  sorted_range_bounds_search #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .used_count(used_count),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .op(op),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .search_key(search_key),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .found(found),
    .first_pos(first_pos),
    .last_pos(last_pos)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // binary search exactly as the hardware probes it: first position whose
  // entry is > key (strict) or >= key, n when no probe hits
  function automatic int bound_probe(input logic signed [KEY_W-1:0] key, input int n,
                                     input bit strict);
    int  lo;
    int  hi;
    int  mid;
    int  ans;
    bit  hit;
    lo = 0;
    hi = n - 1;
    ans = n;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      hit = strict ? (entry_copy[mid] > key) : (entry_copy[mid] >= key);
      if (hit) begin
        ans = mid;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return ans;
  endfunction

  function automatic bounds_t predict_bounds(input logic signed [KEY_W-1:0] key);
    int      n;
    int      lower;
    int      upper;
    bounds_t r;
    // counts above the table depth search the whole table
    n = (count_copy > DEPTH) ? DEPTH : int'(count_copy);
    lower = bound_probe(key, n, 1'b0);
    upper = bound_probe(key, n, 1'b1);
    if (lower == n || entry_copy[lower] != key) begin
      r.found = 1'b0;
      r.first_pos = NOT_FOUND;
      r.last_pos = NOT_FOUND;
    end else begin
      // on an unsorted table upper can land at 0, giving last_pos of all ones
      r.found = 1'b1;
      r.first_pos = POS_W'(lower);
      r.last_pos = POS_W'(upper - 1);
    end
    return r;
  endfunction

  // --------------------------------------------------------------- checking

  always @(posedge clk) begin : check_bounds
    bounds_t want;
    if (!rst && result_valid && !result_stall) begin
      if (bounds_due.size() == 0) begin
        $error("result transfer with nothing pending: found %0b first_pos %0d last_pos %0d",
               found, first_pos, last_pos);
        mismatch_count++;
      end else begin
        want = bounds_due.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found);
          mismatch_count++;
        end
        if (first_pos !== want.first_pos) begin
          $error("first_pos: expected %0d, got %0d", $signed(want.first_pos), first_pos);
          mismatch_count++;
        end
        if (last_pos !== want.last_pos) begin
          $error("last_pos: expected %0d, got %0d", $signed(want.last_pos), last_pos);
          mismatch_count++;
        end
      end
    end
  end

  // result side back-pressure: random stall bursts between quiet stretches
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_stall <= 1'b0;
        // sometimes a long stretch with no stall at all
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20))
          @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // one item transfer; valid stays high afterwards so the next item can follow
  // back to back, the predictor sees the item at the edge it is taken
  task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic signed [KEY_W-1:0] val,
                           input logic signed [KEY_W-1:0] key);
    if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= kind;
    entry_index <= idx;
    entry_value <= val;
    search_key <= key;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (kind == OP_WRITE) begin
      entry_copy[idx] = val;
    end else begin
      bounds_due.push_back(predict_bounds(key));
    end
  endtask

  // unused fields carry random data to show they are ignored
  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic signed [KEY_W-1:0] val);
    send_item(OP_WRITE, idx, val, $urandom);
  endtask

  task automatic query_key(input logic signed [KEY_W-1:0] key);
    send_item(OP_QUERY, IDX_W'($urandom), $urandom, key);
  endtask

  // stop sending, let every result drain, then give trailing writes time to land
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (bounds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called with the block idle
  task automatic set_count(input logic [CNT_W-1:0] n);
    cfg_valid <= 1'b1;
    used_count <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    count_copy = n;
  endtask

  // ascending run from base at positions 0..n-1, about a quarter of steps repeat a value
  task automatic fill_sorted(input int n, input int max_step,
                             input logic signed [KEY_W-1:0] base);
    longint v;
    v = base;
    for (int i = 0; i < n; i++) begin
      write_entry(IDX_W'(i), KEY_W'(v));
      if ($urandom_range(0, 3) != 0) v += $urandom_range(1, max_step);
      if (v > KEY_MAX) v = KEY_MAX;
    end
  endtask

  // mostly keys present in the used range, their neighbors, the extremes and noise
  function automatic logic signed [KEY_W-1:0] pick_key(input int n_eff);
    int                      r;
    logic signed [KEY_W-1:0] k;
    r = $urandom_range(0, 19);
    if (n_eff == 0 || r >= 17) begin
      k = $urandom;
    end else if (r == 16) begin
      k = KEY_MIN;
    end else if (r == 15) begin
      k = KEY_MAX;
    end else begin
      k = entry_copy[$urandom_range(0, n_eff - 1)];
      if (r == 12) k = k - 1;
      if (r == 13 || r == 14) k = k + 1;
    end
    return k;
  endfunction

  // ------------------------------------------------------------------ tests

  // count still at its reset value of zero, then written to zero: nothing found
  task automatic test_empty_table();
    query_key(KEY_MIN);
    query_key(KEY_MAX);
    wait_idle();
    set_count('0);
    query_key('0);
    wait_idle();
  endtask

  // four entries with a repeated middle value and both extremes
  task automatic test_small_table();
    set_count(CNT_W'(4));
    write_entry(IDX_W'(0), KEY_MIN);
    write_entry(IDX_W'(1), 32'sd5);
    write_entry(IDX_W'(2), 32'sd5);
    write_entry(IDX_W'(3), KEY_MAX);
    write_entry('1, -32'sd1);         // top index, outside the used range
    query_key(KEY_MIN);
    query_key(32'sd5);                // run of two
    query_key(KEY_MAX);
    query_key(32'sd4);                // lower bound lands on a larger entry
    query_key(32'sd6);
    query_key(-32'sd1);               // only present beyond used_count
    wait_idle();
    set_count(CNT_W'(1));
    query_key(KEY_MIN);
    query_key(32'sd5);
    wait_idle();
  endtask

  // out of order entries: result follows the probe sequence
  task automatic test_unsorted_table();
    set_count(CNT_W'(3));
    write_entry(IDX_W'(0), 32'sd40);
    write_entry(IDX_W'(1), -32'sd7);
    write_entry(IDX_W'(2), 32'sd40);
    query_key(32'sd40);
    query_key(-32'sd7);
    query_key('0);
    wait_idle();
  endtask

  // whole table written once, so every later count reads only written entries;
  // covers the full depth and counts past it
  task automatic test_full_table();
    set_count(CNT_W'(DEPTH));
    fill_sorted(DEPTH, 8_400_000, KEY_MIN);
    repeat (24) query_key(pick_key(DEPTH));
    wait_idle();
    set_count('1);
    repeat (12) query_key(pick_key(DEPTH));
    wait_idle();
    set_count(CNT_W'(DEPTH + 1));
    repeat (8) query_key(pick_key(DEPTH));
    wait_idle();
  endtask

  // phases of a random count, for short counts a fresh table (mostly sorted), and queries,
  // with the odd stray write mixed in
  task automatic test_random_tables();
    int                      n;
    int                      n_eff;
    int                      r;
    logic signed [KEY_W-1:0] base;
    while (items_sent < ITEMS_TARGET) begin
      calm = (items_sent >= CALM_FROM);
      gaps_on = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      case (r)
        0: begin
          n = 0;
        end
        1: begin
          n = $urandom_range(DEPTH + 1, 2047);
        end
        2: begin
          n = $urandom_range(65, DEPTH);
        end
        default: begin
          n = $urandom_range(1, 64);
        end
      endcase
      n_eff = (n > DEPTH) ? DEPTH : n;
      wait_idle();
      set_count(CNT_W'(n));
      if (n > 0 && n <= 64) begin
        if ($urandom_range(0, 7) == 0) begin
          for (int i = 0; i < n; i++) write_entry(IDX_W'(i), $urandom);
        end else begin
          r = $urandom_range(0, 3);
          base = (r == 0) ? KEY_MIN : (r == 1) ? KEY_MAX - $urandom_range(0, 40) : $urandom;
          fill_sorted(n, 3, base);
        end
      end
      repeat ($urandom_range(4, 16)) begin
        if ($urandom_range(0, 19) == 0) begin
          write_entry(IDX_W'($urandom), $urandom);
        end else begin
          query_key(pick_key(n_eff));
        end
      end
    end
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    used_count <= '0;
    item_valid <= 1'b0;
    op <= OP_WRITE;
    entry_index <= '0;
    entry_value <= '0;
    search_key <= '0;
    count_copy = '0;
    items_sent = 0;
    mismatch_count = 0;
    calm = 1'b0;
    gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_small_table();
    test_unsorted_table();
    test_full_table();
    test_random_tables();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
